>>> rtl/sticky_modifier_key_translator_core_assert.svh
// Assertion macros used by the checker module of the translator.
`ifndef STICKY_MODIFIER_KEY_TRANSLATOR_CORE_ASSERT_SVH
`define STICKY_MODIFIER_KEY_TRANSLATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SMKT_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smkt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SMKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smkt assertion failed");

`endif

>>> rtl/smkt_pkg.sv
`default_nettype none
package smkt_pkg;

  localparam int KEYMAP_ENTRIES = 128;
  localparam int KEY_W          = 7;

  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [1:0] CFG_SHIFT = 2'd0;
  localparam logic [1:0] CFG_FN    = 2'd1;
  localparam logic [1:0] CFG_MENU  = 2'd2;
  localparam logic [1:0] CFG_FILE  = 2'd3;

  localparam logic [7:0] SHIFT_CODE_RST = 8'd225;
  localparam logic [7:0] FN_CODE_RST    = 8'd58;
  localparam logic [7:0] MENU_CODE_RST  = 8'd68;
  localparam logic [7:0] FILE_CODE_RST  = 8'd67;

  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_ONESHOT = 2'd1;
  localparam logic [1:0] MODE_LOCKED  = 2'd2;

  localparam logic [1:0] MENU_OFF  = 2'd0;
  localparam logic [1:0] MENU_ON   = 2'd1;
  localparam logic [1:0] MENU_FILE = 2'd2;

  typedef enum logic [2:0] {
    OP_KEY_DOWN,
    OP_KEY_UP,
    OP_POP,
    OP_WRITE,
    OP_NONE
  } op_t;

  typedef enum logic {
    BK_FETCH,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic [7:0] lower;
    logic [7:0] upper;
    logic [7:0] func;
    logic       is_char;
  } kmap_entry_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] idx;
    kmap_entry_t      entry;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       pr;
    logic       ic;
  } ev_entry_t;

  typedef struct packed {
    logic [7:0] shift_code;
    logic [7:0] fn_code;
    logic [7:0] menu_code;
    logic [7:0] file_code;
  } cfg_t;

  typedef struct packed {
    logic       ev_valid;
    logic [7:0] ev_char;
    logic       ev_pressed;
    logic       ev_is_char;
    logic [1:0] shift_mode;
    logic [1:0] fn_mode;
    logic [1:0] menu_mode;
    logic       refresh;
    logic       overflow;
  } res_t;

  localparam logic [7:0] LETTER_FUNC [26] = '{
    8'd64, 8'hA3, 8'd36, 8'd37, 8'd94, 8'd38, 8'd0, 8'd225, 8'd124, 8'd35,
    8'd44, 8'd63, 8'd39, 8'd58, 8'd59, 8'd123, 8'd0, 8'd58, 8'd32, 8'd92,
    8'd126, 8'd32, 8'd32, 8'd60, 8'd62, 8'd91
  };

  function automatic logic [1:0] cycle_mode(input logic [1:0] m);
    logic [1:0] r;
    case (m)
      MODE_NONE:    r = MODE_ONESHOT;
      MODE_ONESHOT: r = MODE_LOCKED;
      default:      r = MODE_NONE;
    endcase
    return r;
  endfunction

  // Power-on content of one keymap entry.
  function automatic kmap_entry_t default_entry(input logic [KEY_W-1:0] idx);
    kmap_entry_t e;
    logic [7:0]  i8;
    logic [4:0]  li;
    i8 = {1'b0, idx};
    li = 5'(i8 - 8'd4);
    e  = '0;
    case (idx) inside
      [7'd4:7'd29]: begin
        e.lower   = i8 + 8'd93;
        e.upper   = i8 + 8'd61;
        e.func    = LETTER_FUNC[li];
        e.is_char = 1'b1;
      end
      [7'd89:7'd97]: begin
        e.lower   = i8 - 8'd40;
        e.upper   = i8 - 8'd40;
        e.func    = i8 - 8'd40;
        e.is_char = 1'b1;
      end
      7'd40, 7'd41, 7'd42, 7'd101, 7'd116, 7'd118, 7'd127: begin
        e = '{lower: i8, upper: i8, func: i8, is_char: 1'b0};
        if (idx == 7'd101) e = '{8'd58, 8'd58, 8'd58, 1'b0};
        if (idx == 7'd116) e = '{8'd67, 8'd67, 8'd67, 1'b0};
        if (idx == 7'd118) e = '{8'd68, 8'd68, 8'd68, 1'b0};
        if (idx == 7'd127) e = '{8'd225, 8'd225, 8'd225, 1'b0};
      end
      7'd44:  e = '{8'd32, 8'd32, 8'd32, 1'b1};
      7'd79:  e = '{8'd79, 8'd79, 8'd77, 1'b0};
      7'd80:  e = '{8'd80, 8'd80, 8'd74, 1'b0};
      7'd81:  e = '{8'd81, 8'd81, 8'd78, 1'b0};
      7'd82:  e = '{8'd82, 8'd82, 8'd75, 1'b0};
      7'd84:  e = '{8'd47, 8'd47, 8'd47, 1'b1};
      7'd85:  e = '{8'd42, 8'd42, 8'd42, 1'b1};
      7'd86:  e = '{8'd45, 8'd45, 8'd45, 1'b1};
      7'd87:  e = '{8'd43, 8'd43, 8'd43, 1'b1};
      7'd88:  e = '{8'd40, 8'd40, 8'd40, 1'b0};
      7'd98:  e = '{8'd48, 8'd48, 8'd48, 1'b1};
      7'd99:  e = '{8'd46, 8'd46, 8'd46, 1'b1};
      7'd119: e = '{8'd40, 8'd40, 8'd40, 1'b0};
      7'd120: e = '{8'd41, 8'd41, 8'd41, 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

>>> rtl/smkt_if.sv
`default_nettype none
interface smkt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [6:0] key_code;
  logic       pressed;
  logic [6:0] entry_index;
  logic [7:0] entry_lower;
  logic [7:0] entry_upper;
  logic [7:0] entry_func;
  logic       entry_is_char;

  modport source (
    output valid, command, key_code, pressed, entry_index, entry_lower,
           entry_upper, entry_func, entry_is_char,
    input  ready
  );
  modport sink (
    input  valid, command, key_code, pressed, entry_index, entry_lower,
           entry_upper, entry_func, entry_is_char,
    output ready
  );
endinterface

interface smkt_out_if #(parameter int CNT_W = 5);
  logic             valid;
  logic             ready;
  logic             ev_valid;
  logic [7:0]       ev_char;
  logic             ev_pressed;
  logic             ev_is_char;
  logic [CNT_W-1:0] queue_count;
  logic [1:0]       shift_mode;
  logic [1:0]       fn_mode;
  logic [1:0]       menu_mode;
  logic             refresh;
  logic             overflow;

  modport source (
    output valid, ev_valid, ev_char, ev_pressed, ev_is_char, queue_count,
           shift_mode, fn_mode, menu_mode, refresh, overflow,
    input  ready
  );
  modport sink (
    input  valid, ev_valid, ev_char, ev_pressed, ev_is_char, queue_count,
           shift_mode, fn_mode, menu_mode, refresh, overflow,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/smkt_ram.sv
`default_nettype none
module smkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/smkt_front.sv
`default_nettype none
module smkt_front
  import smkt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  smkt_in_if.sink    in_if,
  output logic       cq_valid,
  output cmd_t       cq_head,
  input  wire logic  cq_pop
);

  // Two-entry command queue between the input handshake and the executor.
  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cq_valid    = (cnt_r != 2'd0);
  assign cq_head     = q_r[rd_ptr_r];

  always_comb begin
    cmd_in.key           = in_if.key_code;
    cmd_in.idx           = in_if.entry_index;
    cmd_in.entry.lower   = in_if.entry_lower;
    cmd_in.entry.upper   = in_if.entry_upper;
    cmd_in.entry.func    = in_if.entry_func;
    cmd_in.entry.is_char = in_if.entry_is_char;
    case (in_if.command)
      CMD_KEY:   cmd_in.op = in_if.pressed ? OP_KEY_DOWN : OP_KEY_UP;
      CMD_POP:   cmd_in.op = OP_POP;
      CMD_WRITE: cmd_in.op = OP_WRITE;
      default:   cmd_in.op = OP_NONE;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cq_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cq_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/smkt_back.sv
`default_nettype none
module smkt_back
  import smkt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  wire logic              cq_valid,
  input  cmd_t                   cq_head,
  output logic                   cq_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output res_t                   out_res,
  output logic       [CNT_W-1:0] out_count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  bk_state_t   state_r, state_nxt;
  cmd_t        cmd_r;
  logic        kv_r [KEYMAP_ENTRIES];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [1:0]  shift_r, shift_nxt;
  logic [1:0]  fn_r, fn_nxt;
  logic [1:0]  menu_r, menu_nxt;
  logic        out_valid_r, out_valid_nxt;
  res_t        res_r, res_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic        fetch_go;
  logic        exec_go;
  logic        commit_ok;
  logic [$bits(kmap_entry_t)-1:0] kq;
  logic [$bits(ev_entry_t)-1:0]   eq;
  kmap_entry_t entry;
  ev_entry_t   ev_rd;
  ev_entry_t   ev_wr;
  logic        kwe;
  logic        ewe;

  // The result register can take a new item when empty or being drained.
  assign commit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_FETCH: if (cq_valid) state_nxt = BK_EXEC;
      BK_EXEC:  if (commit_ok) state_nxt = BK_FETCH;
      default:  state_nxt = BK_FETCH;
    endcase
  end

  always_comb begin
    fetch_go = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      BK_FETCH: fetch_go = cq_valid;
      BK_EXEC:  exec_go  = commit_ok;
      default: begin
        fetch_go = 1'b0;
        exec_go  = 1'b0;
      end
    endcase
  end

  assign cq_pop = fetch_go;

  smkt_ram #(
    .WIDTH($bits(kmap_entry_t)),
    .DEPTH(KEYMAP_ENTRIES)
  ) u_kmap (
    .clk   (clk),
    .we    (kwe),
    .waddr (cmd_r.idx),
    .wdata (cmd_r.entry),
    .re    (fetch_go),
    .raddr (cq_head.key),
    .rdata (kq)
  );

  smkt_ram #(
    .WIDTH($bits(ev_entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_evq (
    .clk   (clk),
    .we    (ewe),
    .waddr (tail_r),
    .wdata (ev_wr),
    .re    (fetch_go),
    .raddr (head_r),
    .rdata (eq)
  );

  // Entries never written since reset read as the power-on keymap.
  assign entry = kv_r[cmd_r.key] ? kmap_entry_t'(kq) : default_entry(cmd_r.key);
  assign ev_rd = ev_entry_t'(eq);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    shift_nxt     = shift_r;
    fn_nxt        = fn_r;
    menu_nxt      = menu_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    kwe           = 1'b0;
    ewe           = 1'b0;
    ev_wr.pr      = 1'b1;
    ev_wr.ic      = entry.is_char;
    ev_wr.ch      = entry.lower;
    res_nxt.ev_valid   = 1'b0;
    res_nxt.ev_char    = 8'd0;
    res_nxt.ev_pressed = 1'b0;
    res_nxt.ev_is_char = 1'b0;
    res_nxt.refresh    = 1'b0;
    res_nxt.overflow   = 1'b0;

    if (fn_r != MODE_NONE) begin
      ev_wr.ch = entry.func;
    end else if (shift_r != MODE_NONE) begin
      ev_wr.ch = entry.upper;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (exec_go) begin
      out_valid_nxt = 1'b1;
      case (cmd_r.op)
        OP_KEY_DOWN: begin
          res_nxt.refresh = 1'b1;
          if (entry.lower == cfg.shift_code) begin
            shift_nxt = cycle_mode(shift_r);
          end else if (entry.lower == cfg.fn_code) begin
            fn_nxt = cycle_mode(fn_r);
          end else if (entry.lower == cfg.menu_code) begin
            menu_nxt = (menu_r == MENU_ON) ? MENU_OFF : MENU_ON;
          end else if (entry.lower == cfg.file_code) begin
            if (menu_r == MENU_OFF) menu_nxt = MENU_FILE;
            else if (menu_r == MENU_FILE) menu_nxt = MENU_OFF;
          end else if (fill_r == FULL_CNT) begin
            // A dropped character leaves a one-shot modifier armed.
            res_nxt.overflow = 1'b1;
          end else begin
            ewe      = 1'b1;
            tail_nxt = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
            fill_nxt = fill_r + 1'b1;
            if (fn_r != MODE_NONE) begin
              if (fn_r == MODE_ONESHOT) fn_nxt = MODE_NONE;
            end else if (shift_r == MODE_ONESHOT) begin
              shift_nxt = MODE_NONE;
            end
          end
        end
        OP_POP: begin
          if (fill_r != '0) begin
            res_nxt.ev_valid   = 1'b1;
            res_nxt.ev_char    = ev_rd.ch;
            res_nxt.ev_pressed = ev_rd.pr;
            res_nxt.ev_is_char = ev_rd.ic;
            head_nxt = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
            fill_nxt = fill_r - 1'b1;
          end
        end
        OP_WRITE: kwe = 1'b1;
        default: ;
      endcase
      res_nxt.shift_mode = shift_nxt;
      res_nxt.fn_mode    = fn_nxt;
      res_nxt.menu_mode  = menu_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      shift_r     <= MODE_NONE;
      fn_r        <= MODE_NONE;
      menu_r      <= MENU_OFF;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEYMAP_ENTRIES; i++) begin
        kv_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      shift_r     <= shift_nxt;
      fn_r        <= fn_nxt;
      menu_r      <= menu_nxt;
      out_valid_r <= out_valid_nxt;
      if (kwe) begin
        kv_r[cmd_r.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_go) begin
      cmd_r <= cq_head;
    end
    if (exec_go) begin
      res_r <= res_nxt;
      cnt_r <= fill_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_count = cnt_r;

endmodule
`default_nettype wire

>>> rtl/sticky_modifier_key_translator_core.sv
// Key event translator with sticky shift, fn and menu modifiers.
// in_if carries one command per item: a key event, a pop from the internal
// event queue, or a keymap write. Every accepted item yields exactly one
// result item on out_if, in order, with the modifier modes and the queue
// fill as they stand after that item.
// A two-entry command queue at the input decouples acceptance from the
// executor, which takes one item at a time through a fetch state for the
// registered read of the keymap and event memories and then an execute
// state that updates the modes and queue and loads the result register;
// it fetches the next item only after the last one has been loaded.
// When out_if.ready is low the result register holds; the executor then
// waits with the next item and the input keeps taking items until its
// command queue is full, after which in_if.ready drops.
// Reset (rst_n low at a clock edge) empties all queues, returns the modes to
// none/off and restores the power-on keymap and modifier codes at once.
// cfg_we writes register cfg_index with cfg_data; only while idle.
`default_nettype none
module sticky_modifier_key_translator_core
  import smkt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  smkt_in_if.sink         in_if,
  smkt_out_if.source      out_if,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t             cfg_r;
  logic             cq_valid;
  cmd_t             cq_head;
  logic             cq_pop;
  res_t             res;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shift_code <= SHIFT_CODE_RST;
      cfg_r.fn_code    <= FN_CODE_RST;
      cfg_r.menu_code  <= MENU_CODE_RST;
      cfg_r.file_code  <= FILE_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHIFT: cfg_r.shift_code <= cfg_data;
        CFG_FN:    cfg_r.fn_code    <= cfg_data;
        CFG_MENU:  cfg_r.menu_code  <= cfg_data;
        CFG_FILE:  cfg_r.file_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  smkt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cq_valid (cq_valid),
    .cq_head  (cq_head),
    .cq_pop   (cq_pop)
  );

  smkt_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cq_valid  (cq_valid),
    .cq_head   (cq_head),
    .cq_pop    (cq_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (res),
    .out_count (count)
  );

  assign out_if.ev_valid    = res.ev_valid;
  assign out_if.ev_char     = res.ev_char;
  assign out_if.ev_pressed  = res.ev_pressed;
  assign out_if.ev_is_char  = res.ev_is_char;
  assign out_if.queue_count = count;
  assign out_if.shift_mode  = res.shift_mode;
  assign out_if.fn_mode     = res.fn_mode;
  assign out_if.menu_mode   = res.menu_mode;
  assign out_if.refresh     = res.refresh;
  assign out_if.overflow    = res.overflow;

endmodule
`default_nettype wire

>>> rtl/smkt_checker.sv
`default_nettype none
`include "sticky_modifier_key_translator_core_assert.svh"
module smkt_checker #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             ev_valid,
  input wire logic             ev_pressed,
  input wire logic             refresh,
  input wire logic             overflow,
  input wire logic [CNT_W-1:0] queue_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  `SMKT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A successful pop is never a key press and always returns a pressed key.
  `SMKT_ASSERT(a_pop_shape, clk, rst_n, out_valid && ev_valid, ev_pressed && !refresh && !overflow)

  // A drop only happens on a handled press while the queue is full.
  `SMKT_ASSERT(a_ovf_full, clk, rst_n, out_valid && overflow, refresh && queue_count == FULL_CNT)

  // After a pop at least one slot is free.
  `SMKT_ASSERT(a_pop_room, clk, rst_n, out_valid && ev_valid, queue_count < FULL_CNT)

endmodule

bind sticky_modifier_key_translator_core smkt_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_smkt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .ev_valid    (out_if.ev_valid),
  .ev_pressed  (out_if.ev_pressed),
  .refresh     (out_if.refresh),
  .overflow    (out_if.overflow),
  .queue_count (out_if.queue_count)
);
`default_nettype wire

>>> sim/tb_sticky_modifier_key_translator_core.sv
`default_nettype none
module tb_sticky_modifier_key_translator_core;
  import smkt_pkg::*;

  localparam int QDEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Function layer of the letter keys a..z, first letter in the top byte.
  localparam logic [26*8-1:0] LETTER_FN_LAYER = {
    8'h40, 8'hA3, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h00, 8'hE1, 8'h7C, 8'h23,
    8'h2C, 8'h3F, 8'h27, 8'h3A, 8'h3B, 8'h7B, 8'h00, 8'h3A, 8'h20, 8'h5C,
    8'h7E, 8'h20, 8'h20, 8'h3C, 8'h3E, 8'h5B
  };

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] key_code;
    logic       pressed;
    logic [6:0] entry_index;
    logic [7:0] entry_lower;
    logic [7:0] entry_upper;
    logic [7:0] entry_func;
    logic       entry_is_char;
  } cmd_item_t;

  typedef struct packed {
    logic       ev_valid;
    logic [7:0] ev_char;
    logic       ev_pressed;
    logic       ev_is_char;
    logic [4:0] queue_count;
    logic [1:0] shift_mode;
    logic [1:0] fn_mode;
    logic [1:0] menu_mode;
    logic       refresh;
    logic       overflow;
  } key_report_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  smkt_in_if  in_ch ();
  smkt_out_if out_ch ();

  sticky_modifier_key_translator_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the translator state.
  logic [7:0] km_lower [128];
  logic [7:0] km_upper [128];
  logic [7:0] km_func  [128];
  logic       km_char  [128];
  logic [7:0] ring_ch  [QDEPTH];
  logic       ring_ic  [QDEPTH];
  int         ring_head;
  int         ring_fill;
  logic [1:0] shift_st;
  logic [1:0] fn_st;
  logic [1:0] menu_st;
  logic [7:0] code_shift;
  logic [7:0] code_fn;
  logic [7:0] code_menu;
  logic [7:0] code_file;

  key_report_t pending_reports [$];
  key_report_t want;
  int mismatches;
  int n_items;
  int n_popped;
  int n_empty_pops;
  int n_dropped;
  int n_writes;
  int quiet_left;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #3_000_000;
    $display("FAIL sticky_modifier_key_translator_core");
    $finish;
  end

  function automatic void put_entry(input int idx, input logic [7:0] lo, input logic [7:0] up,
                                    input logic [7:0] fn, input logic flag);
    km_lower[idx] = lo;
    km_upper[idx] = up;
    km_func[idx]  = fn;
    km_char[idx]  = flag;
  endfunction

  function automatic void load_power_on_state();
    for (int i = 0; i < 128; i++) put_entry(i, 8'd0, 8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 26; i++) begin
      put_entry(4 + i, 8'(8'h61 + i), 8'(8'h41 + i), LETTER_FN_LAYER[(25 - i) * 8 +: 8], 1'b1);
    end
    for (int i = 0; i < 9; i++) begin
      put_entry(89 + i, 8'(8'h31 + i), 8'(8'h31 + i), 8'(8'h31 + i), 1'b1);
    end
    put_entry(40, 8'd40, 8'd40, 8'd40, 1'b0);
    put_entry(41, 8'd41, 8'd41, 8'd41, 1'b0);
    put_entry(42, 8'd42, 8'd42, 8'd42, 1'b0);
    put_entry(44, 8'd32, 8'd32, 8'd32, 1'b1);
    put_entry(79, 8'd79, 8'd79, 8'd77, 1'b0);
    put_entry(80, 8'd80, 8'd80, 8'd74, 1'b0);
    put_entry(81, 8'd81, 8'd81, 8'd78, 1'b0);
    put_entry(82, 8'd82, 8'd82, 8'd75, 1'b0);
    put_entry(84, 8'd47, 8'd47, 8'd47, 1'b1);
    put_entry(85, 8'd42, 8'd42, 8'd42, 1'b1);
    put_entry(86, 8'd45, 8'd45, 8'd45, 1'b1);
    put_entry(87, 8'd43, 8'd43, 8'd43, 1'b1);
    put_entry(88, 8'd40, 8'd40, 8'd40, 1'b0);
    put_entry(98, 8'd48, 8'd48, 8'd48, 1'b1);
    put_entry(99, 8'd46, 8'd46, 8'd46, 1'b1);
    put_entry(101, 8'd58, 8'd58, 8'd58, 1'b0);
    put_entry(116, 8'd67, 8'd67, 8'd67, 1'b0);
    put_entry(118, 8'd68, 8'd68, 8'd68, 1'b0);
    put_entry(119, 8'd40, 8'd40, 8'd40, 1'b0);
    put_entry(120, 8'd41, 8'd41, 8'd41, 1'b0);
    put_entry(127, 8'd225, 8'd225, 8'd225, 1'b0);
    ring_head  = 0;
    ring_fill  = 0;
    shift_st   = MODE_NONE;
    fn_st      = MODE_NONE;
    menu_st    = MENU_OFF;
    code_shift = SHIFT_CODE_RST;
    code_fn    = FN_CODE_RST;
    code_menu  = MENU_CODE_RST;
    code_file  = FILE_CODE_RST;
  endfunction

  function automatic logic [1:0] advance_sticky(input logic [1:0] m);
    logic [1:0] r;
    case (m)
      MODE_NONE:    r = MODE_ONESHOT;
      MODE_ONESHOT: r = MODE_LOCKED;
      default:      r = MODE_NONE;
    endcase
    return r;
  endfunction

  // Applies one accepted item to the shadow state and returns its report.
  function automatic key_report_t translate_item(input cmd_item_t it);
    key_report_t r;
    logic [7:0]  lo;
    logic [7:0]  c;
    logic [6:0]  k;
    int          tail;
    r = '0;
    k = it.key_code;
    case (it.command)
      CMD_KEY: begin
        if (it.pressed) begin
          lo = km_lower[k];
          r.refresh = 1'b1;
          if (lo == code_shift) begin
            shift_st = advance_sticky(shift_st);
          end else if (lo == code_fn) begin
            fn_st = advance_sticky(fn_st);
          end else if (lo == code_menu) begin
            menu_st = (menu_st == MENU_ON) ? MENU_OFF : MENU_ON;
          end else if (lo == code_file) begin
            if (menu_st == MENU_OFF) menu_st = MENU_FILE;
            else if (menu_st == MENU_FILE) menu_st = MENU_OFF;
          end else if (ring_fill >= QDEPTH) begin
            // The character is lost and any one-shot modifier stays armed.
            r.overflow = 1'b1;
          end else begin
            if (fn_st != MODE_NONE) begin
              c = km_func[k];
              if (fn_st == MODE_ONESHOT) fn_st = MODE_NONE;
            end else if (shift_st != MODE_NONE) begin
              c = km_upper[k];
              if (shift_st == MODE_ONESHOT) shift_st = MODE_NONE;
            end else begin
              c = lo;
            end
            tail = (ring_head + ring_fill) % QDEPTH;
            ring_ch[tail] = c;
            ring_ic[tail] = km_char[k];
            ring_fill++;
          end
        end
      end
      CMD_POP: begin
        if (ring_fill > 0) begin
          r.ev_valid   = 1'b1;
          r.ev_char    = ring_ch[ring_head];
          r.ev_pressed = 1'b1;
          r.ev_is_char = ring_ic[ring_head];
          ring_head    = (ring_head + 1) % QDEPTH;
          ring_fill--;
        end
      end
      CMD_WRITE: begin
        put_entry(it.entry_index, it.entry_lower, it.entry_upper, it.entry_func,
                  it.entry_is_char);
      end
      default: ;
    endcase
    r.queue_count = 5'(ring_fill);
    r.shift_mode  = shift_st;
    r.fn_mode     = fn_st;
    r.menu_mode   = menu_st;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        compare_field("ev_valid", want.ev_valid, out_ch.ev_valid);
        compare_field("ev_char", want.ev_char, out_ch.ev_char);
        compare_field("ev_pressed", want.ev_pressed, out_ch.ev_pressed);
        compare_field("ev_is_char", want.ev_is_char, out_ch.ev_is_char);
        compare_field("queue_count", want.queue_count, out_ch.queue_count);
        compare_field("shift_mode", want.shift_mode, out_ch.shift_mode);
        compare_field("fn_mode", want.fn_mode, out_ch.fn_mode);
        compare_field("menu_mode", want.menu_mode, out_ch.menu_mode);
        compare_field("refresh", want.refresh, out_ch.refresh);
        compare_field("overflow", want.overflow, out_ch.overflow);
      end
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  initial begin : result_pacing
    int burst;
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      out_ch.ready <= 1'b1;
      repeat (burst) @(negedge clk);
      stall = pick_idle_len();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input cmd_item_t it);
    int gap;
    key_report_t rpt;
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = pick_idle_len();
      if ($urandom_range(0, 49) == 0) quiet_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= it.command;
    in_ch.key_code      <= it.key_code;
    in_ch.pressed       <= it.pressed;
    in_ch.entry_index   <= it.entry_index;
    in_ch.entry_lower   <= it.entry_lower;
    in_ch.entry_upper   <= it.entry_upper;
    in_ch.entry_func    <= it.entry_func;
    in_ch.entry_is_char <= it.entry_is_char;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rpt = translate_item(it);
    pending_reports.push_back(rpt);
    n_items++;
    if (rpt.overflow) n_dropped++;
    if (it.command == CMD_WRITE) n_writes++;
    if (it.command == CMD_POP) begin
      if (rpt.ev_valid) n_popped++;
      else n_empty_pops++;
    end
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    for (int w = 0; w < 20000 && pending_reports.size() != 0; w++) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic program_codes(input logic [7:0] s, input logic [7:0] f,
                               input logic [7:0] m, input logic [7:0] fl);
    cfg_we <= 1'b1; cfg_index <= CFG_SHIFT; cfg_data <= s;
    @(negedge clk);
    cfg_index <= CFG_FN; cfg_data <= f;
    @(negedge clk);
    cfg_index <= CFG_MENU; cfg_data <= m;
    @(negedge clk);
    cfg_index <= CFG_FILE; cfg_data <= fl;
    @(negedge clk);
    cfg_we <= 1'b0;
    code_shift = s;
    code_fn    = f;
    code_menu  = m;
    code_file  = fl;
    @(negedge clk);
  endtask

  function automatic cmd_item_t noise_item();
    cmd_item_t r;
    r.command       = 2'($urandom);
    r.key_code      = 7'($urandom);
    r.pressed       = 1'($urandom);
    r.entry_index   = 7'($urandom);
    r.entry_lower   = 8'($urandom);
    r.entry_upper   = 8'($urandom);
    r.entry_func    = 8'($urandom);
    r.entry_is_char = 1'($urandom);
    return r;
  endfunction

  function automatic cmd_item_t key_item(input logic [6:0] k, input logic p);
    cmd_item_t r;
    r = noise_item();
    r.command  = CMD_KEY;
    r.key_code = k;
    r.pressed  = p;
    return r;
  endfunction

  function automatic cmd_item_t pop_item();
    cmd_item_t r;
    r = noise_item();
    r.command = CMD_POP;
    return r;
  endfunction

  function automatic cmd_item_t write_item(input logic [6:0] idx, input logic [7:0] lo,
                                           input logic [7:0] up, input logic [7:0] fn,
                                           input logic flag);
    cmd_item_t r;
    r = noise_item();
    r.command       = CMD_WRITE;
    r.entry_index   = idx;
    r.entry_lower   = lo;
    r.entry_upper   = up;
    r.entry_func    = fn;
    r.entry_is_char = flag;
    return r;
  endfunction

  function automatic logic [7:0] pick_code(input logic [1:0] which);
    logic [7:0] r;
    case (which)
      CFG_SHIFT: r = code_shift;
      CFG_FN:    r = code_fn;
      CFG_MENU:  r = code_menu;
      default:   r = code_file;
    endcase
    return r;
  endfunction

  // A key whose current lower value equals the code, or any key if none does.
  function automatic logic [6:0] key_for_code(input logic [7:0] code);
    logic [6:0] hit;
    int         n;
    hit = 7'($urandom);
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (km_lower[i] == code) begin
        n++;
        if ($urandom_range(1, n) == 1) hit = 7'(i);
      end
    end
    return hit;
  endfunction

  function automatic logic [6:0] random_key();
    int         roll;
    logic [6:0] k;
    roll = $urandom_range(0, 99);
    if (roll < 20) k = key_for_code(pick_code(2'($urandom)));
    else if (roll < 50) k = 7'($urandom_range(4, 29));
    else if (roll < 60) k = 7'($urandom_range(89, 99));
    else k = 7'($urandom);
    return k;
  endfunction

  function automatic cmd_item_t random_write();
    cmd_item_t r;
    r = noise_item();
    r.command = CMD_WRITE;
    if ($urandom_range(0, 3) == 0) r.entry_lower = pick_code(2'($urandom));
    return r;
  endfunction

  task automatic drain_event_queue();
    while (ring_fill > 0) send_item(pop_item());
    send_item(pop_item());
  endtask

  task automatic test_directed_basics();
    cmd_item_t odd;
    send_item(pop_item());
    send_item(key_item(7'd4, 1'b1));
    send_item(key_item(7'd4, 1'b0));
    send_item(key_item(7'd127, 1'b0));
    send_item(key_item(7'd127, 1'b1));
    send_item(key_item(7'd5, 1'b1));
    send_item(key_item(7'd127, 1'b1));
    send_item(key_item(7'd127, 1'b1));
    send_item(key_item(7'd6, 1'b1));
    send_item(key_item(7'd127, 1'b1));
    // Fn wins over shift; shift stays one-shot after the fn character.
    send_item(key_item(7'd101, 1'b1));
    send_item(key_item(7'd127, 1'b1));
    send_item(key_item(7'd10, 1'b1));
    send_item(key_item(7'd96, 1'b1));
    send_item(key_item(7'd101, 1'b1));
    send_item(key_item(7'd99, 1'b1));
    // Menu and file walk through every mode transition but menu from off to on.
    send_item(key_item(7'd116, 1'b1));
    send_item(key_item(7'd116, 1'b1));
    send_item(key_item(7'd116, 1'b1));
    send_item(key_item(7'd118, 1'b1));
    send_item(key_item(7'd116, 1'b1));
    send_item(key_item(7'd118, 1'b1));
    send_item(key_item(7'd0, 1'b1));
    // An unused command carrying write fields must leave the keymap alone.
    odd = write_item(7'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    odd.command = CMD_UNUSED;
    send_item(odd);
  endtask

  task automatic test_queue_full();
    while (ring_fill < QDEPTH) send_item(key_item(7'($urandom_range(4, 29)), 1'b1));
    send_item(key_item(7'd99, 1'b1));
    send_item(key_item(7'd127, 1'b1));
    send_item(key_item(7'($urandom_range(4, 29)), 1'b1));
    send_item(key_item(7'd101, 1'b1));
    send_item(key_item(7'($urandom_range(4, 29)), 1'b1));
    drain_event_queue();
    send_item(key_item(7'($urandom_range(4, 29)), 1'b1));
    send_item(key_item(7'($urandom_range(4, 29)), 1'b1));
    drain_event_queue();
  endtask

  task automatic test_keymap_writes();
    cmd_item_t wr;
    send_item(write_item(7'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_item(write_item(7'd127, 8'h00, 8'h00, 8'h00, 1'b0));
    send_item(key_item(7'd0, 1'b1));
    send_item(key_item(7'd127, 1'b1));
    send_item(key_item(7'd101, 1'b1));
    send_item(key_item(7'd0, 1'b1));
    send_item(write_item(7'd127, 8'd225, 8'd225, 8'd225, 1'b0));
    send_item(write_item(7'd50, code_menu, 8'h01, 8'h02, 1'b0));
    send_item(key_item(7'd50, 1'b1));
    send_item(key_item(7'd50, 1'b1));
    drain_event_queue();
    repeat (20) begin
      wr = random_write();
      send_item(wr);
      if ($urandom_range(0, 2) == 0) send_item(key_item(key_for_code(code_shift), 1'b1));
      if ($urandom_range(0, 2) == 0) send_item(key_item(key_for_code(code_fn), 1'b1));
      send_item(key_item(wr.entry_index, 1'b1));
      if (ring_fill > 12) drain_event_queue();
    end
    drain_event_queue();
  endtask

  task automatic run_random_traffic(input int count);
    int        pop_pct;
    int        roll;
    cmd_item_t it;
    pop_pct = 30;
    for (int n = 0; n < count; n++) begin
      // Switch at random between stretches that fill the queue and ones that drain it.
      if (n % 60 == 0) pop_pct = ($urandom_range(0, 1) == 1) ? 15 : 55;
      roll = $urandom_range(0, 99);
      if (roll < pop_pct) begin
        it = pop_item();
      end else if (roll < pop_pct + 8) begin
        it = key_item(random_key(), 1'b0);
      end else if (roll < pop_pct + 16) begin
        it = random_write();
      end else if (roll < pop_pct + 18) begin
        it = noise_item();
        it.command = CMD_UNUSED;
      end else begin
        it = key_item(random_key(), 1'b1);
      end
      send_item(it);
    end
  endtask

  task automatic test_code_settings();
    settle();
    program_codes(8'd0, 8'd0, 8'd0, 8'd0);
    run_random_traffic(360);
    settle();
    program_codes(8'd255, 8'd255, 8'd255, 8'd255);
    run_random_traffic(360);
    settle();
    program_codes(8'h61, 8'h62, 8'h63, 8'h64);
    run_random_traffic(360);
    settle();
    program_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random_traffic(360);
    settle();
    program_codes(SHIFT_CODE_RST, FN_CODE_RST, MENU_CODE_RST, FILE_CODE_RST);
    run_random_traffic(360);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_KEY;
    in_ch.key_code      = '0;
    in_ch.pressed       = 1'b0;
    in_ch.entry_index   = '0;
    in_ch.entry_lower   = '0;
    in_ch.entry_upper   = '0;
    in_ch.entry_func    = '0;
    in_ch.entry_is_char = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_SHIFT;
    cfg_data            = '0;
    mismatches          = 0;
    n_items             = 0;
    n_popped            = 0;
    n_empty_pops        = 0;
    n_dropped           = 0;
    n_writes            = 0;
    quiet_left          = 0;
    load_power_on_state();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_queue_full();
    test_keymap_writes();
    test_code_settings();

    settle();
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      mismatches++;
    end
    $display("Sent %0d items over five modifier code settings: %0d events popped,",
             n_items, n_popped);
    $display("%0d pops on an empty queue, %0d presses dropped when full, %0d keymap writes.",
             n_empty_pops, n_dropped, n_writes);
    if (mismatches == 0) begin
      $display("PASS sticky_modifier_key_translator_core");
    end else begin
      $display("FAIL sticky_modifier_key_translator_core");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sticky_modifier_key_translator_core.f
+incdir+rtl
rtl/smkt_pkg.sv
rtl/smkt_if.sv
rtl/smkt_ram.sv
rtl/smkt_front.sv
rtl/smkt_back.sv
rtl/sticky_modifier_key_translator_core.sv
rtl/smkt_checker.sv
sim/tb_sticky_modifier_key_translator_core.sv
